// ----- sv/lbcd_pkg.sv -----
// Shared types for the LRU block cache directory.
// Holds the command and status structs between controller and datapath; no dependencies.
`timescale 1ns / 1ps

package lbcd_pkg;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic cap;   // capture an accepted request
        logic look;  // register the hit and victim decision
        logic upd;   // commit state and load the result register
    } t_lbcd_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic out_valid;  // result register holds an untaken result
    } t_lbcd_stat;

endpackage

// ----- sv/lru_block_cache_directory_core.sv -----
// Top level of the LRU block cache directory: stream ports and field packing.
// Instantiates lbcd_ctrl and lbcd_dpath; depends on lbcd_pkg.
//
//  channel   dir  handshake            payload
//  --------  ---  -------------------  -------------------------------------------
//  request   in   i_s_tvalid/o_s_tready tdata: block_num; tuser: func
//  result    out  o_m_tvalid/i_m_tready tdata: hit, slot, served_block,
//                                       victim_valid, victim_block; tuser: error
//  config    in   i_cfg_wr_en           i_cfg_wr_data: initial_block_count
//
// A request is looked up in the cycle after its transfer (tag compare and
// minimum-stamp tree), then committed once the result register is free, and the
// commit loads the result register that drives o_m_tdata. The next request is taken
// in the commit cycle, so a new request is accepted while the last one commits.
// Reset (synchronous, active low) clears all slots, stamps and the timer and
// sets the block count to 1. A waiting result holds in the output register;
// one more request is still taken, and its commit waits until the register frees.
`timescale 1ns / 1ps

module lru_block_cache_directory_core
    import lbcd_pkg::*;
#(
    parameter int NUM_PAGES      = 8,
    parameter int BLOCK_NUM_BITS = 24,
    parameter int STAMP_BITS     = 32
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    // request: [BLOCK_NUM_BITS-1:0] block_num, zero fill above
    input  logic                                    i_s_tvalid,
    output logic                                    o_s_tready,
    input  logic [((BLOCK_NUM_BITS+7)/8)*8-1:0]     i_s_tdata,
    // request: [0] func
    input  logic [0:0]                              i_s_tuser,
    // result: hit, slot, served_block, victim_valid, victim_block, zero fill above
    output logic                                    o_m_tvalid,
    input  logic                                    i_m_tready,
    output logic [((2*BLOCK_NUM_BITS+$clog2(NUM_PAGES)+2+7)/8)*8-1:0] o_m_tdata,
    // result: [0] error
    output logic [0:0]                              o_m_tuser,
    input  logic                                    i_cfg_wr_en,
    input  logic [BLOCK_NUM_BITS-1:0]               i_cfg_wr_data
);

    localparam int SB    = $clog2(NUM_PAGES);
    localparam int OUT_W = ((2*BLOCK_NUM_BITS+SB+2+7)/8)*8;

    t_lbcd_cmd                 w_cmd;
    t_lbcd_stat                w_stat;
    logic                      w_hit;
    logic [SB-1:0]             w_slot;
    logic [BLOCK_NUM_BITS-1:0] w_served;
    logic                      w_vv;
    logic [BLOCK_NUM_BITS-1:0] w_vb;
    logic                      w_err;

    lbcd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_m_tready (i_m_tready),
        .i_stat     (w_stat),
        .o_s_tready (o_s_tready),
        .o_cmd      (w_cmd)
    );

    lbcd_dpath #(
        .NUM_PAGES      (NUM_PAGES),
        .BLOCK_NUM_BITS (BLOCK_NUM_BITS),
        .STAMP_BITS     (STAMP_BITS)
    ) u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_stat         (w_stat),
        .i_func         (i_s_tuser[0]),
        .i_block_num    (i_s_tdata[BLOCK_NUM_BITS-1:0]),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .i_m_tready     (i_m_tready),
        .o_m_tvalid     (o_m_tvalid),
        .o_hit          (w_hit),
        .o_slot         (w_slot),
        .o_served_block (w_served),
        .o_victim_valid (w_vv),
        .o_victim_block (w_vb),
        .o_error        (w_err)
    );

    // Pack result fields from the lowest bit up
    assign o_m_tdata = OUT_W'({w_vb, w_vv, w_served, w_slot, w_hit});
    assign o_m_tuser = w_err;

endmodule

// ----- sv/lbcd_ctrl.sv -----
// Request sequencer for the LRU block cache directory.
// Depends on lbcd_pkg for the command and status structs.
`timescale 1ns / 1ps

module lbcd_ctrl
    import lbcd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    input  logic       i_m_tready,
    input  t_lbcd_stat i_stat,
    output logic       o_s_tready,
    output t_lbcd_cmd  o_cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_LOOK = 2'd1;
    localparam logic [1:0] S_UPD  = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       w_out_free;

    // Result register can take a new result this cycle
    assign w_out_free = !i_stat.out_valid || i_m_tready;

    // Sequence one request through lookup and commit
    always_comb begin
        n_state    = r_state;
        o_s_tready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            S_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.cap = 1'b1;
                    n_state   = S_LOOK;
                end
            end
            S_LOOK: begin
                o_cmd.look = 1'b1;
                n_state    = S_UPD;
            end
            S_UPD: begin
                if (w_out_free) begin
                    o_cmd.upd  = 1'b1;
                    o_s_tready = 1'b1;
                    if (i_s_tvalid) begin
                        o_cmd.cap = 1'b1;
                        n_state   = S_LOOK;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Advance the state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ----- sv/lbcd_dpath.sv -----
// Datapath of the LRU block cache directory: slot tags, stamps, timer, block count,
// tag compare, minimum-stamp tree and result register. Depends on lbcd_pkg.
`timescale 1ns / 1ps

module lbcd_dpath
    import lbcd_pkg::*;
#(
    parameter int NUM_PAGES      = 8,
    parameter int BLOCK_NUM_BITS = 24,
    parameter int STAMP_BITS     = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  t_lbcd_cmd                       i_cmd,
    output t_lbcd_stat                      o_stat,
    input  logic                            i_func,
    input  logic [BLOCK_NUM_BITS-1:0]       i_block_num,
    input  logic                            i_cfg_wr_en,
    input  logic [BLOCK_NUM_BITS-1:0]       i_cfg_wr_data,
    input  logic                            i_m_tready,
    output logic                            o_m_tvalid,
    output logic                            o_hit,
    output logic [$clog2(NUM_PAGES)-1:0]    o_slot,
    output logic [BLOCK_NUM_BITS-1:0]       o_served_block,
    output logic                            o_victim_valid,
    output logic [BLOCK_NUM_BITS-1:0]       o_victim_block,
    output logic                            o_error
);

    localparam int SB     = $clog2(NUM_PAGES);
    localparam int LEVELS = SB;
    localparam int P      = 1 << LEVELS;

    // Directory state
    logic [BLOCK_NUM_BITS-1:0] r_tag   [NUM_PAGES];
    logic [NUM_PAGES-1:0]      r_valid;
    logic [STAMP_BITS-1:0]     r_stamp [NUM_PAGES];
    logic [STAMP_BITS-1:0]     r_timer;
    logic [BLOCK_NUM_BITS-1:0] r_count;

    // Captured request
    logic                      r_func;
    logic [BLOCK_NUM_BITS-1:0] r_blk;

    // Registered decision
    logic                      r_d_err;
    logic                      r_d_hit;
    logic [SB-1:0]             r_d_idx;
    logic [BLOCK_NUM_BITS-1:0] r_d_blk;
    logic                      r_d_vv;
    logic [BLOCK_NUM_BITS-1:0] r_d_vb;
    logic [STAMP_BITS-1:0]     r_d_timer;
    logic                      r_d_wrap;

    // Result register
    logic                      r_out_valid;
    logic                      r_out_hit;
    logic [SB-1:0]             r_out_slot;
    logic [BLOCK_NUM_BITS-1:0] r_out_served;
    logic                      r_out_vv;
    logic [BLOCK_NUM_BITS-1:0] r_out_vb;
    logic                      r_out_err;

    // Lookup logic
    logic [STAMP_BITS-1:0]     w_timer_inc;
    logic                      w_wrap;
    logic [BLOCK_NUM_BITS-1:0] w_eff_blk;
    logic                      w_err;
    logic                      w_hit;
    logic [SB-1:0]             w_hit_idx;
    logic [SB-1:0]             w_vic_idx;
    logic [STAMP_BITS-1:0]     w_tval [LEVELS+1][P];
    logic [SB-1:0]             w_tidx [LEVELS+1][P];

    assign w_timer_inc = r_timer + 1'b1;
    assign w_wrap      = (w_timer_inc == '0);
    assign w_eff_blk   = r_func ? r_count : r_blk;
    assign w_err       = r_func ? (r_count == '1) : (r_blk >= r_count);

    // Compare the tag in every valid slot, lowest match wins
    always_comb begin
        w_hit     = 1'b0;
        w_hit_idx = '0;
        for (int i = NUM_PAGES - 1; i >= 0; i--) begin
            if (r_valid[i] && (r_tag[i] == w_eff_blk)) begin
                w_hit     = 1'b1;
                w_hit_idx = SB'(i);
            end
        end
    end

    // Minimum-stamp tree; the left side wins ties so the lowest index is kept
    always_comb begin
        for (int l = 0; l <= LEVELS; l++) begin
            for (int j = 0; j < P; j++) begin
                w_tval[l][j] = '1;
                w_tidx[l][j] = '0;
            end
        end
        for (int i = 0; i < NUM_PAGES; i++) begin
            w_tval[0][i] = w_wrap ? '0 : r_stamp[i];
            w_tidx[0][i] = SB'(i);
        end
        for (int l = 0; l < LEVELS; l++) begin
            for (int j = 0; j < (P >> (l + 1)); j++) begin
                if (w_tval[l][2*j+1] < w_tval[l][2*j]) begin
                    w_tval[l+1][j] = w_tval[l][2*j+1];
                    w_tidx[l+1][j] = w_tidx[l][2*j+1];
                end else begin
                    w_tval[l+1][j] = w_tval[l][2*j];
                    w_tidx[l+1][j] = w_tidx[l][2*j];
                end
            end
        end
    end

    assign w_vic_idx = w_tidx[LEVELS][0];

    // Capture the request and register the decision
    always_ff @(posedge i_clk) begin
        if (i_cmd.cap) begin
            r_func <= i_func;
            r_blk  <= i_block_num;
        end
        if (i_cmd.look) begin
            r_d_err   <= w_err;
            r_d_hit   <= w_hit;
            r_d_idx   <= w_hit ? w_hit_idx : w_vic_idx;
            r_d_blk   <= w_eff_blk;
            r_d_vv    <= !w_hit && r_valid[w_vic_idx];
            r_d_vb    <= (!w_hit && r_valid[w_vic_idx]) ? r_tag[w_vic_idx] : '0;
            r_d_timer <= w_timer_inc;
            r_d_wrap  <= w_wrap;
        end
    end

    // Commit tags, stamps, timer and block count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_timer <= '0;
            r_count <= BLOCK_NUM_BITS'(1);
            for (int i = 0; i < NUM_PAGES; i++) begin
                r_tag[i]   <= '0;
                r_stamp[i] <= '0;
            end
        end else begin
            if (i_cfg_wr_en) begin
                r_count <= i_cfg_wr_data;
            end
            if (i_cmd.upd && !r_d_err) begin
                r_timer <= r_d_timer;
                // On a wrap the timer is zero, so clearing covers the served slot too
                if (r_d_wrap) begin
                    for (int i = 0; i < NUM_PAGES; i++) begin
                        r_stamp[i] <= '0;
                    end
                end else begin
                    r_stamp[r_d_idx] <= r_d_timer;
                end
                if (!r_d_hit) begin
                    r_tag[r_d_idx]   <= r_d_blk;
                    r_valid[r_d_idx] <= 1'b1;
                end
                if (r_func) begin
                    r_count <= r_count + 1'b1;
                end
            end
        end
    end

    // Load the result register, drop it once transferred
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.upd) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.upd) begin
            r_out_err    <= r_d_err;
            r_out_hit    <= !r_d_err && r_d_hit;
            r_out_slot   <= r_d_err ? '0 : r_d_idx;
            r_out_served <= r_d_err ? '0 : r_d_blk;
            r_out_vv     <= !r_d_err && r_d_vv;
            r_out_vb     <= r_d_err ? '0 : r_d_vb;
        end
    end

    assign o_stat.out_valid = r_out_valid;
    assign o_m_tvalid       = r_out_valid;
    assign o_hit            = r_out_hit;
    assign o_slot           = r_out_slot;
    assign o_served_block   = r_out_served;
    assign o_victim_valid   = r_out_vv;
    assign o_victim_block   = r_out_vb;
    assign o_error          = r_out_err;

`ifndef SYNTHESIS
    a_err_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_err |-> !r_out_hit && !r_out_vv)
        else $error("error result carries hit or victim");

    a_hit_no_victim: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_hit |-> !r_out_vv)
        else $error("hit result reports a victim");

    a_valid_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_valid) >= $past($countones(r_valid)))
        else $error("slot valid bit was cleared");

    a_miss_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.upd && !r_d_err && !r_d_hit |=> r_valid[$past(r_d_idx)])
        else $error("retagged slot not marked valid");
`endif

endmodule

// ----- sim/tb.sv -----
// Self-checking bench for lru_block_cache_directory_core: a directed table, then random traffic.
// Tracks the directory in its own model of slots, stamps and block count; needs lbcd_pkg and the RTL.
`timescale 1ns / 1ps

module tb;

    localparam int PAGES     = 8;
    localparam int BLK_W     = 24;
    localparam int STAMP_W   = 32;
    localparam int SLOT_W    = $clog2(PAGES);
    localparam int IN_W      = ((BLK_W + 7) / 8) * 8;
    localparam int OUT_W     = ((2 * BLK_W + SLOT_W + 2 + 7) / 8) * 8;
    localparam int SLOT_LO   = 1;
    localparam int SERVED_LO = SLOT_LO + SLOT_W;
    localparam int VV_BIT    = SERVED_LO + BLK_W;
    localparam int VICTIM_LO = VV_BIT + 1;

    localparam logic [BLK_W-1:0] BLK_MAX = {BLK_W{1'b1}};
    localparam int RANDOM_PER_PHASE = 500;
    localparam int CYCLE_LIMIT      = 600000;

    typedef enum logic {FUNC_FETCH = 1'b0, FUNC_CREATE = 1'b1} t_func;
    typedef enum logic {ROW_REQ, ROW_CFG} t_row_kind;

    typedef struct {
        logic              hit;
        logic [SLOT_W-1:0] slot;
        logic [BLK_W-1:0]  served;
        logic              victim_valid;
        logic [BLK_W-1:0]  victim;
        logic              err;
    } t_lookup;

    typedef struct {
        t_row_kind        kind;
        t_func            fn;
        logic [BLK_W-1:0] value;   // block number, or register value for ROW_CFG
        bit               typed;   // use exp instead of the predictor
        t_lookup          exp;
    } t_row;

    localparam t_lookup NO_EXP    = '{1'b0, 3'd0, 24'd0, 1'b0, 24'd0, 1'b0};
    localparam t_lookup EXP_ERROR = '{1'b0, 3'd0, 24'd0, 1'b0, 24'd0, 1'b1};

    // Directed table: extremes of block_num and count, every op, refusals, stale tags
    localparam int ROWS = 27;
    t_row directed_plan [ROWS] = '{
        '{ROW_REQ, FUNC_FETCH,  24'h000000, 1'b1, '{1'b0, 3'd0, 24'd0, 1'b0, 24'd0, 1'b0}},
        '{ROW_REQ, FUNC_FETCH,  24'h000000, 1'b1, '{1'b1, 3'd0, 24'd0, 1'b0, 24'd0, 1'b0}},
        '{ROW_REQ, FUNC_FETCH,  24'h000001, 1'b1, EXP_ERROR},
        '{ROW_REQ, FUNC_FETCH,  24'hFFFFFF, 1'b1, EXP_ERROR},
        '{ROW_REQ, FUNC_CREATE, 24'hFFFFFF, 1'b1, '{1'b0, 3'd1, 24'd1, 1'b0, 24'd0, 1'b0}},
        '{ROW_REQ, FUNC_FETCH,  24'h000001, 1'b1, '{1'b1, 3'd1, 24'd1, 1'b0, 24'd0, 1'b0}},
        '{ROW_REQ, FUNC_CREATE, 24'h000000, 1'b0, NO_EXP},
        '{ROW_REQ, FUNC_CREATE, 24'h123456, 1'b0, NO_EXP},
        '{ROW_REQ, FUNC_CREATE, 24'h000000, 1'b0, NO_EXP},
        '{ROW_REQ, FUNC_CREATE, 24'h000000, 1'b0, NO_EXP},
        '{ROW_REQ, FUNC_CREATE, 24'h000000, 1'b0, NO_EXP},
        '{ROW_REQ, FUNC_CREATE, 24'h000000, 1'b0, NO_EXP},
        '{ROW_REQ, FUNC_CREATE, 24'h000000, 1'b0, NO_EXP},
        '{ROW_REQ, FUNC_FETCH,  24'h000000, 1'b0, NO_EXP},
        '{ROW_REQ, FUNC_FETCH,  24'h000008, 1'b0, NO_EXP},
        '{ROW_CFG, FUNC_FETCH,  24'h000000, 1'b0, NO_EXP},
        '{ROW_REQ, FUNC_FETCH,  24'h000000, 1'b1, EXP_ERROR},
        '{ROW_REQ, FUNC_CREATE, 24'h000000, 1'b0, NO_EXP},
        '{ROW_CFG, FUNC_FETCH,  24'hFFFFFF, 1'b0, NO_EXP},
        '{ROW_REQ, FUNC_CREATE, 24'h000000, 1'b1, EXP_ERROR},
        '{ROW_REQ, FUNC_FETCH,  24'hFFFFFE, 1'b0, NO_EXP},
        '{ROW_REQ, FUNC_FETCH,  24'hFFFFFF, 1'b1, EXP_ERROR},
        '{ROW_REQ, FUNC_FETCH,  24'hAAAAAA, 1'b0, NO_EXP},
        '{ROW_REQ, FUNC_FETCH,  24'h555555, 1'b0, NO_EXP},
        '{ROW_CFG, FUNC_FETCH,  24'hFFFFFE, 1'b0, NO_EXP},
        '{ROW_REQ, FUNC_CREATE, 24'h000000, 1'b0, NO_EXP},
        '{ROW_REQ, FUNC_CREATE, 24'h000000, 1'b1, EXP_ERROR}
    };

    // DUT ports, known from time zero
    logic             i_clk         = 1'b0;
    logic             i_rst_n       = 1'b0;
    logic             i_s_tvalid    = 1'b0;
    logic             o_s_tready;
    logic [IN_W-1:0]  i_s_tdata     = '0;
    logic [0:0]       i_s_tuser     = '0;
    logic             o_m_tvalid;
    logic             i_m_tready    = 1'b0;
    logic [OUT_W-1:0] o_m_tdata;
    logic [0:0]       o_m_tuser;
    logic             i_cfg_wr_en   = 1'b0;
    logic [BLK_W-1:0] i_cfg_wr_data = '0;

    // Directory model
    logic [BLK_W-1:0]   dir_tag   [PAGES];
    logic               dir_valid [PAGES];
    logic [STAMP_W-1:0] dir_stamp [PAGES];
    logic [STAMP_W-1:0] access_clock;
    logic [BLK_W-1:0]   blocks_held;

    t_lookup pending_lookups [$];
    int      mismatches   = 0;
    int      cycle_count  = 0;
    int      src_idle_pct = 0;
    int      dst_idle_pct = 0;

    lru_block_cache_directory_core #(
        .NUM_PAGES      (PAGES),
        .BLOCK_NUM_BITS (BLK_W),
        .STAMP_BITS     (STAMP_W)
    ) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_s_tvalid    (i_s_tvalid),
        .o_s_tready    (o_s_tready),
        .i_s_tdata     (i_s_tdata),
        .i_s_tuser     (i_s_tuser),
        .o_m_tvalid    (o_m_tvalid),
        .i_m_tready    (i_m_tready),
        .o_m_tdata     (o_m_tdata),
        .o_m_tuser     (o_m_tuser),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // Advance the directory by one request and return what it should report
    function automatic t_lookup predict_lookup(input t_func fn, input logic [BLK_W-1:0] blk);
        t_lookup          r;
        logic [BLK_W-1:0] want;
        int               victim;
        bit               found;
        r     = NO_EXP;
        found = 1'b0;
        if (fn == FUNC_CREATE) begin
            if (blocks_held >= BLK_MAX) begin
                r.err = 1'b1;
                return r;
            end
            blocks_held = blocks_held + 1'b1;
            want = blocks_held - 1'b1;
        end else begin
            if (blk >= blocks_held) begin
                r.err = 1'b1;
                return r;
            end
            want = blk;
        end
        access_clock = access_clock + 1'b1;
        // timer wrap restarts all stamps
        if (access_clock == '0) begin
            for (int i = 0; i < PAGES; i++) dir_stamp[i] = '0;
        end
        r.served = want;
        for (int i = 0; i < PAGES; i++) begin
            if (!found && dir_valid[i] && dir_tag[i] == want) begin
                found        = 1'b1;
                dir_stamp[i] = access_clock;
                r.hit        = 1'b1;
                r.slot       = SLOT_W'(i);
            end
        end
        if (!found) begin
            // oldest stamp wins, ties to the lowest slot
            victim = 0;
            for (int i = 1; i < PAGES; i++) begin
                if (dir_stamp[i] < dir_stamp[victim]) victim = i;
            end
            r.slot         = SLOT_W'(victim);
            r.victim_valid = dir_valid[victim];
            r.victim       = dir_valid[victim] ? dir_tag[victim] : '0;
            dir_tag[victim]   = want;
            dir_valid[victim] = 1'b1;
            dir_stamp[victim] = access_clock;
        end
        return r;
    endfunction

    // Offer one request, hold it until the transfer, then record its expectation
    task automatic push_request(input t_func fn, input logic [BLK_W-1:0] blk,
                                input bit typed, input t_lookup typed_exp);
        t_lookup pred;
        if ($urandom_range(99) < src_idle_pct) begin
            i_s_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < src_idle_pct);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= IN_W'(blk);
        i_s_tuser  <= fn;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        pred = predict_lookup(fn, blk);
        if (typed) pending_lookups.push_back(typed_exp);
        else pending_lookups.push_back(pred);
    endtask

    // Drop valid and hold off until every result has been taken
    task automatic drain_results();
        i_s_tvalid <= 1'b0;
        while (pending_lookups.size() != 0) @(posedge i_clk);
    endtask

    // Reload the block count while the block is idle
    task automatic load_block_count(input logic [BLK_W-1:0] count);
        drain_results();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= count;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        blocks_held = count;
    endtask

    // Mostly in-range fetches near recent blocks, plus creates and refusals
    task automatic draw_request(output t_func fn, output logic [BLK_W-1:0] blk);
        int pick;
        int s;
        int held;
        int lo;
        pick = $urandom_range(99);
        held = int'(blocks_held);
        fn   = FUNC_FETCH;
        blk  = BLK_W'($urandom);
        if (pick < 12) begin
            fn = FUNC_CREATE;
        end else if (pick < 22) begin
            blk = BLK_W'($urandom_range(int'(BLK_MAX), held));
        end else if (held > 0) begin
            s = $urandom_range(PAGES - 1);
            lo = (held > 16) ? held - 16 : 0;
            if (pick < 55 && dir_valid[s] && dir_tag[s] < blocks_held) blk = dir_tag[s];
            else if (pick < 85) blk = BLK_W'($urandom_range(held - 1, lo));
            else blk = BLK_W'($urandom_range(held - 1, 0));
        end
    endtask

    function automatic logic [BLK_W-1:0] pick_block_count();
        case ($urandom_range(9))
            0:       return '0;
            1:       return BLK_MAX;
            2:       return BLK_MAX - BLK_W'($urandom_range(3));
            3, 4, 5, 6: return BLK_W'($urandom_range(24, 1));
            default: return BLK_W'($urandom);
        endcase
    endfunction

    task automatic check_field(input string name, input logic [BLK_W-1:0] want,
                               input logic [BLK_W-1:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endtask

    // Receiver: random stalls, compare each result transfer with the oldest expectation
    always @(posedge i_clk) begin
        t_lookup want;
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= ($urandom_range(99) >= dst_idle_pct);
            if (o_m_tvalid && i_m_tready) begin
                if (pending_lookups.size() == 0) begin
                    $error("result transfer with no request outstanding");
                    mismatches++;
                end else begin
                    want = pending_lookups.pop_front();
                    check_field("hit", want.hit, o_m_tdata[0]);
                    check_field("slot", want.slot, o_m_tdata[SLOT_LO +: SLOT_W]);
                    check_field("served_block", want.served, o_m_tdata[SERVED_LO +: BLK_W]);
                    check_field("victim_valid", want.victim_valid, o_m_tdata[VV_BIT]);
                    check_field("victim_block", want.victim, o_m_tdata[VICTIM_LO +: BLK_W]);
                    check_field("error", want.err, o_m_tuser[0]);
                end
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        t_func            fn;
        logic [BLK_W-1:0] blk;
        int               issued;
        int               seg_len;
        for (int i = 0; i < PAGES; i++) begin
            dir_tag[i]   = '0;
            dir_valid[i] = 1'b0;
            dir_stamp[i] = '0;
        end
        access_clock = '0;
        blocks_held  = BLK_W'(1);

        // hold reset, then release it
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table, with both sides busy
        src_idle_pct = 23;
        dst_idle_pct = 23;
        for (int r = 0; r < ROWS; r++) begin
            if (directed_plan[r].kind == ROW_CFG) load_block_count(directed_plan[r].value);
            else push_request(directed_plan[r].fn, directed_plan[r].value,
                              directed_plan[r].typed, directed_plan[r].exp);
        end

        // random traffic in three idle patterns, count reloaded per segment
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0:       begin src_idle_pct = 23; dst_idle_pct = 86; end
                1:       begin src_idle_pct = 86; dst_idle_pct = 23; end
                default: begin src_idle_pct = 0;  dst_idle_pct = 0;  end
            endcase
            issued = 0;
            while (issued < RANDOM_PER_PHASE) begin
                load_block_count(pick_block_count());
                seg_len = $urandom_range(120, 40);
                for (int k = 0; k < seg_len; k++) begin
                    draw_request(fn, blk);
                    push_request(fn, blk, 1'b0, NO_EXP);
                end
                issued += seg_len;
            end
        end

        drain_results();
        repeat (8) @(posedge i_clk);
        if (mismatches == 0 && pending_lookups.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ----- files.f -----
sv/lbcd_pkg.sv
sv/lbcd_ctrl.sv
sv/lbcd_dpath.sv
sv/lru_block_cache_directory_core.sv
sim/tb.sv
